/* rtl/core/scs_pkg.sv */
// ----------------------------------------------------------------------------
// scs_pkg
// Shared sizes, codes and constants of the sparse column suppressor.
// ----------------------------------------------------------------------------
`default_nettype none

package scs_pkg;

   // Frame geometry
   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 512;
   localparam int FRAME_DEPTH = MAX_HEIGHT * MAX_WIDTH;
   localparam int FRAME_AW    = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
   localparam int COL_AW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   // Field widths
   localparam int ROW_W = 9;
   localparam int COL_W = 10;
   localparam int PIX_W = 8;
   localparam int CNT_W = 10;

   // Operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Pixel and count constants
   localparam logic [PIX_W-1:0] WHITE_VALUE     = 8'd255;
   localparam logic [CNT_W-1:0] COUNT_MAX       = 10'd1023;
   localparam logic [CNT_W-1:0] MIN_COUNT_RESET = 10'd100;

endpackage : scs_pkg

`default_nettype wire

/* rtl/core/scs_if.sv */
// ----------------------------------------------------------------------------
// scs_req_if / scs_rsp_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface scs_req_if;
   logic                       valid;
   logic                       ready;
   logic                       operation;
   logic [scs_pkg::ROW_W-1:0]  row_index;
   logic [scs_pkg::COL_W-1:0]  col_index;
   logic [scs_pkg::PIX_W-1:0]  pixel_in;

   modport source (output valid, operation, row_index, col_index, pixel_in,
                   input ready);
   modport sink   (input valid, operation, row_index, col_index, pixel_in,
                   output ready);
endinterface : scs_req_if

interface scs_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [scs_pkg::PIX_W-1:0]  pixel_out;
   logic                       column_kept;

   modport source (output valid, pixel_out, column_kept, input ready);
   modport sink   (input valid, pixel_out, column_kept, output ready);
endinterface : scs_rsp_if

`default_nettype wire

/* rtl/core/sparse_column_suppressor.sv */
// ----------------------------------------------------------------------------
// sparse_column_suppressor
// Frame store with per-column white-pixel counts; reads zero out thin columns.
// ----------------------------------------------------------------------------
//   Channel   Dir   Handshake          Payload
//   req_chan  in    valid/ready        operation, row_index, col_index, pixel_in
//   rsp_chan  out   valid/ready        pixel_out, column_kept
//   csr_*     in    write enable only  min_count (10 bits)
//
// One item per cycle while input ready is high: an accepted item reads the
// frame and count memories into registers, then, from stage one, updates the
// memories or answers into the result register. Input ready drops only while
// a read in stage one waits on a held result item; any item behind it waits
// too. Back-to-back loads to the same column forward the count just written.
// Reset is synchronous and clears control state and min_count (to 100);
// the memories are not cleared. Loads give no result item.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_column_suppressor (
   input  wire                       clock,
   input  wire                       reset,
   scs_req_if.sink                   req_chan,
   scs_rsp_if.source                 rsp_chan,
   input  wire                       csr_wr_en,
   input  wire [scs_pkg::CNT_W-1:0]  csr_wr_data
);
   import scs_pkg::*;

   typedef struct packed {
      logic                 operation;
      logic                 row_zero;
      logic                 in_range;
      logic [COL_AW-1:0]    col;
      logic [FRAME_AW-1:0]  addr;
      logic [PIX_W-1:0]     pixel;
   } stage_type;

   // Memories
   logic [PIX_W-1:0] frame_mem [FRAME_DEPTH];
   logic [CNT_W-1:0] count_mem [MAX_WIDTH];

   logic [CNT_W-1:0]    min_count_ff;
   logic                s1_valid_ff;
   stage_type           s1_ff, s1_in;
   logic [PIX_W-1:0]    frame_rd_ff;
   logic [CNT_W-1:0]    count_rd_ff;

   logic                fwd_valid_ff, fwd_valid_in;
   logic [COL_AW-1:0]   fwd_col_ff;
   logic [CNT_W-1:0]    fwd_cnt_ff;
   logic [FRAME_AW-1:0] fwd_addr_ff;
   logic [PIX_W-1:0]    fwd_pix_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]    rsp_pix_ff, rsp_pix_in;
   logic                rsp_kept_ff, rsp_kept_in;

   logic                req_accept;
   logic                s1_stall;
   logic                s1_advance;
   logic                mem_wr_en;
   logic [CNT_W-1:0]    cnt_old;
   logic [PIX_W-1:0]    pix_old;
   logic                hit;
   logic [CNT_W:0]      cnt_sum;
   logic [CNT_W-1:0]    cnt_new;
   logic                kept;

   // Decode the incoming item
   always_comb begin
      s1_in.operation = req_chan.operation;
      s1_in.row_zero  = (req_chan.row_index == '0);
      s1_in.in_range  = (32'(req_chan.row_index) < MAX_HEIGHT) &&
                        (32'(req_chan.col_index) < MAX_WIDTH);
      s1_in.col       = COL_AW'(req_chan.col_index);
      s1_in.addr      = FRAME_AW'(req_chan.row_index) * FRAME_AW'(MAX_WIDTH) +
                        FRAME_AW'(req_chan.col_index);
      s1_in.pixel     = req_chan.pixel_in;
   end

   // Handshake control
   assign s1_stall   = s1_valid_ff && (s1_ff.operation == OP_READ) &&
                       rsp_valid_ff && !rsp_chan.ready;
   assign s1_advance = !s1_stall;
   assign req_chan.ready = s1_advance;
   assign req_accept = req_chan.valid && s1_advance;
   assign mem_wr_en  = s1_valid_ff && s1_advance && s1_ff.in_range &&
                       (s1_ff.operation == OP_LOAD);

   // Forward the value written by the item that last left stage one
   always_comb begin
      cnt_old = (fwd_valid_ff && (fwd_col_ff == s1_ff.col)) ? fwd_cnt_ff : count_rd_ff;
      pix_old = (fwd_valid_ff && (fwd_addr_ff == s1_ff.addr)) ? fwd_pix_ff : frame_rd_ff;
   end

   // Count update: restart at row zero, saturate elsewhere
   always_comb begin
      hit     = (s1_ff.pixel == WHITE_VALUE);
      cnt_sum = {1'b0, cnt_old} + {{CNT_W{1'b0}}, hit};
      if (s1_ff.row_zero) begin
         cnt_new = {{(CNT_W-1){1'b0}}, hit};
      end else if (cnt_sum[CNT_W]) begin
         cnt_new = COUNT_MAX;
      end else begin
         cnt_new = cnt_sum[CNT_W-1:0];
      end
      kept = s1_ff.in_range && (cnt_old >= min_count_ff);
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_pix_in   = rsp_pix_ff;
      rsp_kept_in  = rsp_kept_ff;
      if (s1_valid_ff && s1_advance && (s1_ff.operation == OP_READ)) begin
         rsp_valid_in = 1'b1;
         rsp_pix_in   = kept ? pix_old : '0;
         rsp_kept_in  = kept;
      end
   end

   assign fwd_valid_in = mem_wr_en;

   // Frame memory: write on load, read on accept
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         frame_mem[s1_ff.addr] <= s1_ff.pixel;
      end
      if (req_accept) begin
         frame_rd_ff <= frame_mem[s1_in.addr];
      end
   end

   // Column count memory
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         count_mem[s1_ff.col] <= cnt_new;
      end
      if (req_accept) begin
         count_rd_ff <= count_mem[s1_in.col];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_count_ff <= MIN_COUNT_RESET;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            min_count_ff <= csr_wr_data;
         end
         if (s1_advance) begin
            s1_valid_ff  <= req_chan.valid;
            fwd_valid_ff <= fwd_valid_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= s1_in;
      end
      if (s1_advance) begin
         fwd_col_ff  <= s1_ff.col;
         fwd_cnt_ff  <= cnt_new;
         fwd_addr_ff <= s1_ff.addr;
         fwd_pix_ff  <= s1_ff.pixel;
      end
      rsp_pix_ff  <= rsp_pix_in;
      rsp_kept_ff <= rsp_kept_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pixel_out   = rsp_pix_ff;
   assign rsp_chan.column_kept = rsp_kept_ff;

endmodule : sparse_column_suppressor

`default_nettype wire

/* rtl/core/scs_checker.sv */
// ----------------------------------------------------------------------------
// scs_checker
// Port-level checks of the sparse column suppressor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module scs_checker (
   input wire                       clock,
   input wire                       reset,
   input wire                       req_valid,
   input wire                       req_ready,
   input wire                       req_operation,
   input wire                       rsp_valid,
   input wire                       rsp_ready,
   input wire [scs_pkg::PIX_W-1:0]  pixel_out,
   input wire                       column_kept
);
   import scs_pkg::*;

   // Hold a stalled result item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pixel_out) && $stable(column_kept))
      else $error("stalled result item changed");

   // Drop the pixel of a suppressed column
   a_suppress_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !column_kept |-> pixel_out == '0)
      else $error("suppressed column gave a nonzero pixel");

   // Start empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A new result follows an accepted read through stage one and the result register
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_operation == OP_READ, 2))
      else $error("result item without a matching read");

endmodule : scs_checker

bind sparse_column_suppressor scs_checker u_scs_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_operation (req_chan.operation),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .pixel_out     (rsp_chan.pixel_out),
   .column_kept   (rsp_chan.column_kept)
);

`default_nettype wire
